FILE: rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and the arctangent table for the axis-angle
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // Default number of CORDIC iterations and the table length.
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;

  // Angle codes in Q9.6 degrees.
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  // CORDIC widths: x/y in Q30 with headroom, z in Q22 degrees.
  localparam int unsigned X_W = 34;
  localparam int unsigned Z_W = 32;

  // CORDIC gain compensation, Q2.30.
  localparam logic signed [X_W-1:0] CORDIC_START = X_W'(652032874);

  // Axis limits in Q1.14.
  localparam logic signed [15:0] AXIS_MAX = 16'sd16384;
  localparam logic signed [15:0] AXIS_MIN = -16'sd16384;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle_deg;
  } aavr_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               clipped;
  } aavr_out_t;

  // Data that rides alongside the CORDIC stages.
  typedef struct packed {
    logic [2:0][31:0] vec;
    logic [2:0][15:0] axis;
    logic             neg;
  } aavr_side_t;

  // atan(2^-k) in degrees, Q22.
  function automatic logic signed [Z_W-1:0] atan_q22(input int unsigned k);
    logic signed [Z_W-1:0] a;
    case (k)
      0:       a = 32'sd188743680;
      1:       a = 32'sd111421900;
      2:       a = 32'sd58872272;
      3:       a = 32'sd29884485;
      4:       a = 32'sd15000234;
      5:       a = 32'sd7507429;
      6:       a = 32'sd3754631;
      7:       a = 32'sd1877430;
      8:       a = 32'sd938729;
      9:       a = 32'sd469366;
      10:      a = 32'sd234683;
      11:      a = 32'sd117342;
      12:      a = 32'sd58671;
      13:      a = 32'sd29335;
      14:      a = 32'sd14668;
      15:      a = 32'sd7334;
      16:      a = 32'sd3667;
      17:      a = 32'sd1833;
      18:      a = 32'sd917;
      19:      a = 32'sd458;
      20:      a = 32'sd229;
      21:      a = 32'sd115;
      22:      a = 32'sd57;
      23:      a = 32'sd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// Fully pipelined CORDIC in rotation mode, degree units; one iteration per
// register stage. Produces cosine and sine in Q2.30 and carries side data.
// ----------------------------------------------------------------------------
module aavr_cordic
  import aavr_pkg::*;
#(
  parameter int unsigned CordicSteps = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [Z_W-1:0] z_i,
  input  aavr_side_t            side_i,
  output logic                  valid_o,
  output logic signed [X_W-1:0] cos_o,
  output logic signed [X_W-1:0] sin_o,
  output aavr_side_t            side_o
);

  localparam int unsigned NumStg = (CordicSteps > ATAN_LEN) ? ATAN_LEN : CordicSteps;

  logic [NumStg-1:0]     vld_q;
  logic signed [X_W-1:0] x_q [NumStg];
  logic signed [X_W-1:0] y_q [NumStg];
  logic signed [Z_W-1:0] z_q [NumStg];
  aavr_side_t            side_q [NumStg];

  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    logic                  vld_in;
    logic signed [X_W-1:0] x_in;
    logic signed [X_W-1:0] y_in;
    logic signed [Z_W-1:0] z_in;
    aavr_side_t            side_in;

    // Select stage source: port for the first stage, previous stage else
    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign x_in    = CORDIC_START;
      assign y_in    = '0;
      assign z_in    = z_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Advance valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (z_in >= 0) begin
        x_q[k] <= x_in - (y_in >>> k);
        y_q[k] <= y_in + (x_in >>> k);
        z_q[k] <= z_in - atan_q22(k);
      end else begin
        x_q[k] <= x_in + (y_in >>> k);
        y_q[k] <= y_in - (x_in >>> k);
        z_q[k] <= z_in + atan_q22(k);
      end
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[NumStg-1];
  assign cos_o   = x_q[NumStg-1];
  assign sin_o   = y_q[NumStg-1];
  assign side_o  = side_q[NumStg-1];

endmodule

FILE: rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rotates a Q16.16 vector about a Q1.14 unit axis by an angle in Q9.6
// degrees using the Rodrigues matrix; saturates and flags overflow.
// ----------------------------------------------------------------------------
//  channel   | ports                 | handshake
//  ----------+-----------------------+-------------------------------------
//  command   | start, busy, in_i     | taken when start high and busy low
//  result    | done_o, res_o         | one-cycle strobe, never held off
//
//  One transaction enters every clock cycle; busy stays low.
//  The pipeline has one angle reduction stage, one stage per CORDIC
//  iteration (steps capped at 24) and five matrix stages.
//  Reset clears only the valid bits; payload registers are not reset.
//  The result side has no backpressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation
  import aavr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  aavr_in_t  in_i,
  output logic      done_o,
  output aavr_out_t res_o
);

  // No backpressure anywhere
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage R: reduce and fold the angle, clamp the axis
  // --------------------------------------------------------------------------
  logic signed [16:0]    ang_a, ang_b, ang_c, ang_d;
  logic                  fold_neg;
  logic signed [15:0]    ax_in [3];
  logic signed [15:0]    ax_cl [3];
  logic                  r_vld_q;
  logic signed [Z_W-1:0] r_z_q;
  aavr_side_t            r_side_q;

  always_comb begin
    ang_a = 17'(in_i.angle_deg);
    if (ang_a >= 17'(FULL_TURN)) begin
      ang_b = ang_a - 17'(FULL_TURN);
    end else if (ang_a <= -17'(FULL_TURN)) begin
      ang_b = ang_a + 17'(FULL_TURN);
    end else begin
      ang_b = ang_a;
    end
    if (ang_b >= 17'(HALF_TURN)) begin
      ang_c = ang_b - 17'(FULL_TURN);
    end else if (ang_b < -17'(HALF_TURN)) begin
      ang_c = ang_b + 17'(FULL_TURN);
    end else begin
      ang_c = ang_b;
    end
    fold_neg = 1'b0;
    ang_d    = ang_c;
    if (ang_c > 17'(QUARTER_TURN)) begin
      ang_d    = ang_c - 17'(HALF_TURN);
      fold_neg = 1'b1;
    end else if (ang_c < -17'(QUARTER_TURN)) begin
      ang_d    = ang_c + 17'(HALF_TURN);
      fold_neg = 1'b1;
    end
  end

  assign ax_in[0] = in_i.axis_x;
  assign ax_in[1] = in_i.axis_y;
  assign ax_in[2] = in_i.axis_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ax_in[i] > AXIS_MAX) begin
        ax_cl[i] = AXIS_MAX;
      end else if (ax_in[i] < AXIS_MIN) begin
        ax_cl[i] = AXIS_MIN;
      end else begin
        ax_cl[i] = ax_in[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    r_z_q             <= Z_W'(ang_d) <<< 16;
    r_side_q.vec[0]   <= in_i.vec_x;
    r_side_q.vec[1]   <= in_i.vec_y;
    r_side_q.vec[2]   <= in_i.vec_z;
    r_side_q.axis[0]  <= ax_cl[0];
    r_side_q.axis[1]  <= ax_cl[1];
    r_side_q.axis[2]  <= ax_cl[2];
    r_side_q.neg      <= fold_neg;
  end

  // --------------------------------------------------------------------------
  // CORDIC pipeline
  // --------------------------------------------------------------------------
  logic                  k_vld;
  logic signed [X_W-1:0] k_cos, k_sin;
  aavr_side_t            k_side;

  aavr_cordic #(
    .CordicSteps(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_vld_q),
    .z_i     (r_z_q),
    .side_i  (r_side_q),
    .valid_o (k_vld),
    .cos_o   (k_cos),
    .sin_o   (k_sin),
    .side_o  (k_side)
  );

  // --------------------------------------------------------------------------
  // Stage M1: unfold sign, axis products, axis times sine
  // --------------------------------------------------------------------------
  logic signed [X_W:0]   c_v, s_v;
  logic signed [X_W+1:0] t_v;
  logic signed [X_W:0]   c28_v;
  logic signed [15:0]    ux [3];
  logic signed [31:0]    uu_v [6];
  logic signed [50:0]    us_v [3];

  logic                  m1_vld_q;
  logic signed [31:0]    m1_c28_q;
  logic signed [X_W+1:0] m1_t_q;
  logic signed [31:0]    m1_uu_q [6];
  logic signed [50:0]    m1_us_q [3];
  logic [2:0][31:0]      m1_vec_q;

  assign ux[0] = $signed(k_side.axis[0]);
  assign ux[1] = $signed(k_side.axis[1]);
  assign ux[2] = $signed(k_side.axis[2]);

  always_comb begin
    c_v   = k_side.neg ? -(X_W+1)'(k_cos) : (X_W+1)'(k_cos);
    s_v   = k_side.neg ? -(X_W+1)'(k_sin) : (X_W+1)'(k_sin);
    t_v   = (X_W+2)'(64'sd1073741824) - (X_W+2)'(c_v);
    c28_v = (c_v + (X_W+1)'(2)) >>> 2;
    uu_v[0] = ux[0] * ux[0];
    uu_v[1] = ux[1] * ux[1];
    uu_v[2] = ux[2] * ux[2];
    uu_v[3] = ux[0] * ux[1];
    uu_v[4] = ux[0] * ux[2];
    uu_v[5] = ux[1] * ux[2];
    for (int i = 0; i < 3; i++) begin
      us_v[i] = 51'(ux[i]) * 51'(s_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= k_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_c28_q <= c28_v[31:0];
    m1_t_q   <= t_v;
    m1_uu_q  <= uu_v;
    m1_us_q  <= us_v;
    m1_vec_q <= k_side.vec;
  end

  // --------------------------------------------------------------------------
  // Stage M2: scale axis products by (1 - cos), round sine terms
  // --------------------------------------------------------------------------
  logic signed [67:0] ut_p [6];
  logic signed [67:0] ut_r [6];
  logic signed [50:0] us_r [3];

  logic               m2_vld_q;
  logic signed [31:0] m2_c28_q;
  logic signed [31:0] m2_tu_q [6];
  logic signed [31:0] m2_s_q [3];
  logic [2:0][31:0]   m2_vec_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ut_p[i] = 68'(m1_uu_q[i]) * 68'(m1_t_q);
      ut_r[i] = (ut_p[i] + 68'sh20000000) >>> 30;
    end
    for (int i = 0; i < 3; i++) begin
      us_r[i] = (m1_us_q[i] + 51'sh8000) >>> 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      m2_tu_q[i] <= ut_r[i][31:0];
    end
    for (int i = 0; i < 3; i++) begin
      m2_s_q[i] <= us_r[i][31:0];
    end
    m2_c28_q <= m1_c28_q;
    m2_vec_q <= m1_vec_q;
  end

  // --------------------------------------------------------------------------
  // Stage M3: assemble the rotation matrix, Q4.28
  // --------------------------------------------------------------------------
  logic               m3_vld_q;
  logic signed [31:0] m3_m_q [9];
  logic [2:0][31:0]   m3_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m3_m_q[0] <= m2_c28_q + m2_tu_q[0];
    m3_m_q[4] <= m2_c28_q + m2_tu_q[1];
    m3_m_q[8] <= m2_c28_q + m2_tu_q[2];
    m3_m_q[1] <= m2_tu_q[3] - m2_s_q[2];
    m3_m_q[3] <= m2_tu_q[3] + m2_s_q[2];
    m3_m_q[2] <= m2_tu_q[4] + m2_s_q[1];
    m3_m_q[6] <= m2_tu_q[4] - m2_s_q[1];
    m3_m_q[5] <= m2_tu_q[5] - m2_s_q[0];
    m3_m_q[7] <= m2_tu_q[5] + m2_s_q[0];
    m3_vec_q  <= m2_vec_q;
  end

  // --------------------------------------------------------------------------
  // Stage M4: matrix by vector products
  // --------------------------------------------------------------------------
  logic               m4_vld_q;
  logic signed [63:0] m4_p_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_vld_q <= 1'b0;
    end else begin
      m4_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m4_p_q[i*3+j] <= 64'(m3_m_q[i*3+j]) * 64'($signed(m3_vec_q[j]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M5: sum rows, round to Q16, saturate
  // --------------------------------------------------------------------------
  logic signed [65:0] acc_v [3];
  logic signed [65:0] acc_r [3];
  logic signed [31:0] rot_v [3];
  logic [2:0]         clip_v;

  logic               m5_vld_q;
  aavr_out_t          m5_res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_v[i] = 66'(m4_p_q[i*3]) + 66'(m4_p_q[i*3+1]) + 66'(m4_p_q[i*3+2]);
      acc_r[i] = (acc_v[i] + 66'sh8000000) >>> 28;
      clip_v[i] = 1'b0;
      if (acc_r[i] > 66'sh7FFFFFFF) begin
        rot_v[i]  = 32'sh7FFFFFFF;
        clip_v[i] = 1'b1;
      end else if (acc_r[i] < -66'sh80000000) begin
        rot_v[i]  = 32'sh80000000;
        clip_v[i] = 1'b1;
      end else begin
        rot_v[i] = acc_r[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m5_vld_q <= 1'b0;
    end else begin
      m5_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m5_res_q.rot_x   <= rot_v[0];
    m5_res_q.rot_y   <= rot_v[1];
    m5_res_q.rot_z   <= rot_v[2];
    m5_res_q.clipped <= |clip_v;
  end

  assign done_o = m5_vld_q;
  assign res_o  = m5_res_q;

endmodule
